FILE: design/mapt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapt_pkg
// Shared constants, types and status codes of the MAC address packet tracker.
// ----------------------------------------------------------------------------
package mapt_pkg;

	localparam int TABLE_ENTRIES    = 256;
	localparam int LANES            = 8;
	localparam int LANE_W           = $clog2(LANES);
	localparam int ROWS             = (TABLE_ENTRIES + LANES - 1) / LANES;
	localparam int ROW_W            = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ADDR_W           = ROW_W + LANE_W;
	localparam int SLOTS            = ROWS * LANES;
	localparam int CNT_W            = ADDR_W + 1;

	localparam int MAC_W            = 48;
	localparam int COUNT_W          = 64;
	localparam int TIME_W           = 64;
	localparam int LEN_W            = 16;
	localparam int STATUS_W         = 2;
	localparam int MIN_HEADER_BYTES = 14;

	localparam int S_TDATA_W        = 176;
	localparam int M_TDATA_W        = 176;

	typedef logic [MAC_W-1:0]    mac_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [TIME_W-1:0]   time_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [ROW_W-1:0]    row_t;
	typedef logic [LANE_W-1:0]   lane_t;
	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [CNT_W-1:0]    fill_t;
	typedef mac_t [LANES-1:0]    key_row_t;

	typedef struct packed {
		logic  hit;
		lane_t lane;
	} match_t;

	localparam status_t ST_SHORT = 2'd0;
	localparam status_t ST_HIT   = 2'd1;
	localparam status_t ST_NEW   = 2'd2;
	localparam status_t ST_FULL  = 2'd3;

endpackage

FILE: design/mapt_key_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapt_key_store
// Key memory, one row of LANES keys per address, registered row read and
// single-lane write.
// ----------------------------------------------------------------------------
module mapt_key_store import mapt_pkg::*; (
	input  logic     clk,
	input  logic     rd_en,
	input  row_t     rd_row,
	output key_row_t rd_data,
	input  logic     wr_en,
	input  row_t     wr_row,
	input  lane_t    wr_lane,
	input  mac_t     wr_key
);

	key_row_t mem [ROWS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_row][wr_lane] <= wr_key;
		end
		if (rd_en) begin
			rd_data <= mem[rd_row];
		end
	end

endmodule

FILE: design/mapt_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapt_match
// Compares one key row against the lookup key; lanes at or above the fill
// count are not live.
// ----------------------------------------------------------------------------
module mapt_match import mapt_pkg::*; (
	input  key_row_t row_data,
	input  row_t     row,
	input  fill_t    fill,
	input  mac_t     key,
	output match_t   result
);

	logic [LANES-1:0] eq;

	always_comb begin
		eq = '0;
		for (int l = 0; l < LANES; l++) begin
			eq[l] = (fill_t'({row, lane_t'(l)}) < fill) && (row_data[l] == key);
		end
	end

	always_comb begin
		result.hit  = |eq;
		result.lane = '0;
		for (int l = 0; l < LANES; l++) begin
			if (eq[l]) begin
				result.lane = lane_t'(l);
			end
		end
	end

endmodule

FILE: design/mapt_entry_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mapt_entry_store
// Per-entry packet count and first-seen time, registered read, count and
// time written with separate enables.
// ----------------------------------------------------------------------------
module mapt_entry_store import mapt_pkg::*; (
	input  logic   clk,
	input  logic   rd_en,
	input  addr_t  rd_addr,
	output count_t rd_count,
	output time_t  rd_first_seen,
	input  logic   wr_en,
	input  addr_t  wr_addr,
	input  count_t wr_count,
	input  logic   wr_ts_en,
	input  time_t  wr_first_seen
);

	count_t count_mem [SLOTS];
	time_t  ts_mem    [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			count_mem[wr_addr] <= wr_count;
		end
		if (wr_en && wr_ts_en) begin
			ts_mem[wr_addr] <= wr_first_seen;
		end
		if (rd_en) begin
			rd_count      <= count_mem[rd_addr];
			rd_first_seen <= ts_mem[rd_addr];
		end
	end

endmodule

FILE: design/mac_address_packet_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_address_packet_tracker_unit
// Learning table that counts frames per MAC address.
// ----------------------------------------------------------------------------
// Usage:
// One item on the s_axis side is one frame header; one item leaves on the
// m_axis side for each. The key (source MAC on ingress, destination MAC on
// egress) is looked up in a table of TABLE_ENTRIES entries: a hit bumps the
// count, a miss takes the lowest free entry, a full table drops the frame.
// Entries fill in order, so the fill count marks the live entries.
// Flow: a short frame goes from accept straight to the result, a lookup in an
// empty table straight to the miss step. Otherwise the key memory is scanned
// one row of LANES keys per cycle, stopping at a hit, up to ROWS = 32 rows,
// bounded by the single key memory read port. One item is in flight at a
// time; the next is accepted once its result moves to the output register.
// Reset clears the fill count, so the table comes up empty at once.
// The result sits in an output register; a stalled m_axis holds it, and the
// next item is accepted and worked on up to its result meanwhile.
// ----------------------------------------------------------------------------
module mac_address_packet_tracker_unit import mapt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// dest_mac[47:0], src_mac[95:48], frame_length[111:96], now_ns[175:112]
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// is_ingress[0]
	input  logic                 s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// key_mac[47:0], count_after[111:48], first_seen[175:112]
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	// status[1:0]
	output logic [STATUS_W-1:0]  m_axis_tuser
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_HIT_UPD = 3'd2;
	localparam logic [2:0] S_MISS    = 3'd3;
	localparam logic [2:0] S_RESULT  = 3'd4;

	logic [2:0] state_q;
	fill_t      fill_q;
	mac_t       key_q;
	time_t      now_q;
	row_t       last_row_q;
	row_t       issue_row_q;
	logic       issue_more_q;
	logic       cmp_valid_q;
	row_t       cmp_row_q;
	addr_t      hit_addr_q;

	status_t    res_status_q;
	mac_t       res_key_q;
	count_t     res_count_q;
	time_t      res_ts_q;

	logic       out_valid_q;
	status_t    out_status_q;
	mac_t       out_key_q;
	count_t     out_count_q;
	time_t      out_ts_q;

	mac_t             in_dest;
	mac_t             in_src;
	logic [LEN_W-1:0] in_len;
	time_t            in_now;
	logic             accept;
	fill_t            fill_m1;
	logic             full;

	key_row_t   key_row;
	match_t     match;
	logic       key_wr_en;
	logic       ent_rd_en;
	addr_t      ent_rd_addr;
	count_t     ent_rd_count;
	time_t      ent_rd_ts;
	logic       ent_wr_en;
	addr_t      ent_wr_addr;
	count_t     ent_wr_count;
	logic       ent_wr_ts_en;
	logic       load_out;

	assign in_dest = s_axis_tdata[47:0];
	assign in_src  = s_axis_tdata[95:48];
	assign in_len  = s_axis_tdata[111:96];
	assign in_now  = s_axis_tdata[175:112];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign fill_m1       = fill_q - fill_t'(1);
	assign full          = (fill_q == fill_t'(TABLE_ENTRIES));
	assign load_out      = (state_q == S_RESULT) && (!out_valid_q || m_axis_tready);

	mapt_key_store u_key_store (
		.clk     (clk),
		.rd_en   ((state_q == S_SCAN) && issue_more_q),
		.rd_row  (issue_row_q),
		.rd_data (key_row),
		.wr_en   (key_wr_en),
		.wr_row  (fill_q[ADDR_W-1:LANE_W]),
		.wr_lane (fill_q[LANE_W-1:0]),
		.wr_key  (key_q)
	);

	mapt_match u_match (
		.row_data (key_row),
		.row      (cmp_row_q),
		.fill     (fill_q),
		.key      (key_q),
		.result   (match)
	);

	mapt_entry_store u_entry_store (
		.clk           (clk),
		.rd_en         (ent_rd_en),
		.rd_addr       (ent_rd_addr),
		.rd_count      (ent_rd_count),
		.rd_first_seen (ent_rd_ts),
		.wr_en         (ent_wr_en),
		.wr_addr       (ent_wr_addr),
		.wr_count      (ent_wr_count),
		.wr_ts_en      (ent_wr_ts_en),
		.wr_first_seen (now_q)
	);

	assign key_wr_en    = (state_q == S_MISS) && !full;
	assign ent_rd_en    = (state_q == S_SCAN) && cmp_valid_q && match.hit;
	assign ent_rd_addr  = {cmp_row_q, match.lane};
	assign ent_wr_en    = (state_q == S_HIT_UPD) || key_wr_en;
	assign ent_wr_ts_en = key_wr_en;
	assign ent_wr_addr  = key_wr_en ? fill_q[ADDR_W-1:0] : hit_addr_q;
	assign ent_wr_count = key_wr_en ? count_t'(1) : ent_rd_count + count_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			issue_more_q <= 1'b0;
			cmp_valid_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						issue_more_q <= 1'b1;
						cmp_valid_q  <= 1'b0;
						if (in_len < LEN_W'(MIN_HEADER_BYTES)) begin
							state_q <= S_RESULT;
						end else if (fill_q == '0) begin
							state_q <= S_MISS;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue_more_q) begin
						issue_more_q <= (issue_row_q != last_row_q);
					end
					cmp_valid_q <= issue_more_q;
					if (cmp_valid_q && match.hit) begin
						state_q <= S_HIT_UPD;
					end else if (cmp_valid_q && cmp_row_q == last_row_q) begin
						state_q <= S_MISS;
					end
				end
				S_HIT_UPD: begin
					state_q <= S_RESULT;
				end
				S_MISS: begin
					if (!full) begin
						fill_q <= fill_q + fill_t'(1);
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q       <= s_axis_tuser ? in_src : in_dest;
			now_q       <= in_now;
			last_row_q  <= fill_m1[ADDR_W-1:LANE_W];
			issue_row_q <= '0;
			res_status_q <= ST_SHORT;
			res_key_q    <= '0;
			res_count_q  <= '0;
			res_ts_q     <= '0;
		end
		if (state_q == S_SCAN) begin
			if (issue_more_q) begin
				issue_row_q <= issue_row_q + row_t'(1);
			end
			cmp_row_q <= issue_row_q;
			if (ent_rd_en) begin
				hit_addr_q <= ent_rd_addr;
			end
		end
		if (state_q == S_HIT_UPD) begin
			res_status_q <= ST_HIT;
			res_key_q    <= key_q;
			res_count_q  <= ent_wr_count;
			res_ts_q     <= ent_rd_ts;
		end
		if (state_q == S_MISS) begin
			res_key_q <= key_q;
			if (full) begin
				res_status_q <= ST_FULL;
				res_count_q  <= '0;
				res_ts_q     <= '0;
			end else begin
				res_status_q <= ST_NEW;
				res_count_q  <= count_t'(1);
				res_ts_q     <= now_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= res_status_q;
			out_key_q    <= res_key_q;
			out_count_q  <= res_count_q;
			out_ts_q     <= res_ts_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_ts_q, out_count_q, out_key_q};
	assign m_axis_tuser  = out_status_q;

endmodule

FILE: sim/mac_address_packet_tracker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_address_packet_tracker_unit_tb
// Self-checking bench for the MAC address learning table. Frame headers are
// streamed in with random gaps while the result side stalls at random; a
// shadow table in the bench works out each status, key, count and first-seen
// time, and every result is checked in order against it. The run covers short
// frames, key selection by direction, learning until the table is full, drops
// on a full table and a final back-to-back stretch.
// ----------------------------------------------------------------------------
module mac_address_packet_tracker_unit_tb;
	import mapt_pkg::*;

	localparam int WATCHDOG_CYCLES = 4000;
	localparam int DRAIN_CYCLES    = 64;

	typedef struct packed {
		status_t status;
		mac_t    key;
		count_t  count_after;
		time_t   first_seen;
	} tracker_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	logic                 s_axis_tuser = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]  m_axis_tuser;

	// shadow of the learning table
	logic   learned_valid [TABLE_ENTRIES] = '{default: 1'b0};
	mac_t   learned_key   [TABLE_ENTRIES];
	count_t learned_count [TABLE_ENTRIES];
	time_t  learned_first [TABLE_ENTRIES];

	tracker_result_t pending_results[$];
	mac_t            seen_macs[$];
	int              errors = 0;
	bit              idle_on = 1'b1;

	mac_address_packet_tracker_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic mac_t rand_mac();
		return mac_t'({$urandom(), $urandom()});
	endfunction

	function automatic time_t rand_time();
		return {$urandom(), $urandom()};
	endfunction

	function automatic tracker_result_t predict_frame(input mac_t dmac, input mac_t smac,
			input logic ingress, input logic [LEN_W-1:0] flen, input time_t now);
		tracker_result_t r;
		int free_idx;
		int i;
		r = '0;
		free_idx = -1;
		if (flen < MIN_HEADER_BYTES)
			return r;
		r.key = ingress ? smac : dmac;
		for (i = 0; i < TABLE_ENTRIES; i++) begin
			if (learned_valid[i]) begin
				if (learned_key[i] == r.key) begin
					learned_count[i] = learned_count[i] + 1'b1;
					r.status      = ST_HIT;
					r.count_after = learned_count[i];
					r.first_seen  = learned_first[i];
					return r;
				end
			end else if (free_idx < 0) begin
				free_idx = i;
			end
		end
		if (free_idx < 0) begin
			r.status = ST_FULL;
			return r;
		end
		learned_valid[free_idx] = 1'b1;
		learned_key[free_idx]   = r.key;
		learned_count[free_idx] = count_t'(1);
		learned_first[free_idx] = now;
		r.status      = ST_NEW;
		r.count_after = count_t'(1);
		r.first_seen  = now;
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s mismatch: got %h expected %h", $realtime, field, got, want);
		errors++;
	endtask

	task automatic send_frame(input mac_t dmac, input mac_t smac, input logic ingress,
			input logic [LEN_W-1:0] flen, input time_t now);
		logic took;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {now, flen, smac, dmac};
		s_axis_tuser  <= ingress;
		do begin
			@(negedge clk);
			took = s_axis_tready;
			@(posedge clk);
		end while (!took);
		pending_results.push_back(predict_frame(dmac, smac, ingress, flen, now));
	endtask

	// new_pct: share of frames that carry a key not sent before
	task automatic send_random_frame(input int new_pct);
		mac_t key;
		mac_t other;
		logic ingress;
		logic [LEN_W-1:0] flen;
		ingress = 1'($urandom_range(0, 1));
		other   = rand_mac();
		if (seen_macs.size() == 0 || $urandom_range(0, 99) < new_pct) begin
			key = rand_mac();
			// near miss: one bit away from a known key
			if (seen_macs.size() != 0 && $urandom_range(0, 3) == 0)
				key = seen_macs[$urandom_range(0, seen_macs.size() - 1)]
					^ (mac_t'(1) << $urandom_range(0, MAC_W - 1));
			seen_macs.push_back(key);
		end else begin
			key = seen_macs[$urandom_range(0, seen_macs.size() - 1)];
		end
		case ($urandom_range(0, 9))
			0: flen = LEN_W'($urandom_range(0, MIN_HEADER_BYTES - 1));
			1: flen = LEN_W'(MIN_HEADER_BYTES);
			2: flen = '1;
			default: flen = LEN_W'($urandom_range(MIN_HEADER_BYTES, 65535));
		endcase
		if (ingress)
			send_frame(other, key, ingress, flen, rand_time());
		else
			send_frame(key, other, ingress, flen, rand_time());
	endtask

	task automatic test_short_frames();
		send_frame(rand_mac(), rand_mac(), 1'b0, 16'd0, rand_time());
		send_frame('1, '1, 1'b1, LEN_W'(MIN_HEADER_BYTES - 1), '1);
		send_frame(rand_mac(), rand_mac(), 1'b0, 16'd1, '0);
		send_frame('0, '0, 1'b1, 16'd7, rand_time());
	endtask

	task automatic test_key_select();
		send_frame(rand_mac(), '0, 1'b1, LEN_W'(MIN_HEADER_BYTES), '0);
		send_frame('1, '0, 1'b0, '1, '1);
		send_frame('0, rand_mac(), 1'b0, 16'd64, rand_time());
		send_frame(rand_mac(), '1, 1'b1, 16'd1500, rand_time());
		send_frame(rand_mac(), '0, 1'b1, 16'd9000, rand_time());
		send_frame(48'h0000_0000_0001, '1, 1'b0, 16'd60, rand_time());
		send_frame(48'h8000_0000_0000, '0, 1'b0, 16'd60, rand_time());
		send_frame(rand_mac(), '0, 1'b1, LEN_W'(MIN_HEADER_BYTES - 1), rand_time());
		send_frame('0, 48'h0000_0000_0001, 1'b1, 16'd100, rand_time());
		send_frame(48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 1'b1, 16'd100, rand_time());
		send_frame('1, rand_mac(), 1'b0, LEN_W'(MIN_HEADER_BYTES), rand_time());
		seen_macs.push_back('0);
		seen_macs.push_back('1);
		seen_macs.push_back(48'h0000_0000_0001);
		seen_macs.push_back(48'h8000_0000_0000);
		seen_macs.push_back(48'h7FFF_FFFF_FFFF);
	endtask

	task automatic test_table_fill();
		repeat (700) send_random_frame(50);
	endtask

	task automatic test_table_full();
		repeat (800) send_random_frame(20);
	endtask

	task automatic test_back_to_back();
		idle_on = 1'b0;
		repeat (350) send_random_frame(30);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_frames();
		test_key_select();
		test_table_fill();
		test_table_full();
		test_back_to_back();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("mac_address_packet_tracker_unit_tb OK");
		else
			$display("mac_address_packet_tracker_unit_tb NOT OK");
		$finish;
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// outputs are stable at the falling edge; ready was set at the last rising edge
	initial begin
		tracker_result_t want;
		forever begin
			@(negedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected item", m_axis_tdata[63:0], '0);
				end else begin
					want = pending_results.pop_front();
					if (m_axis_tuser !== want.status)
						report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
					if (m_axis_tdata[47:0] !== want.key)
						report_mismatch("key_mac", 64'(m_axis_tdata[47:0]), 64'(want.key));
					if (m_axis_tdata[111:48] !== want.count_after)
						report_mismatch("count_after", m_axis_tdata[111:48], want.count_after);
					if (m_axis_tdata[175:112] !== want.first_seen)
						report_mismatch("first_seen", m_axis_tdata[175:112], want.first_seen);
				end
			end
		end
	end

	initial begin
		int stall_cycles;
		stall_cycles = 0;
		@(posedge arst_n);
		while (stall_cycles < WATCHDOG_CYCLES) begin
			@(negedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("%0t: no item moved for %0d cycles", $realtime, WATCHDOG_CYCLES);
		$display("mac_address_packet_tracker_unit_tb NOT OK");
		$finish;
	end

endmodule
